FILE: sv/humidity_sensor_heater_and_average_unit_macros.svh
// Assertion macros for the humidity sensor heater and average unit.
// Used by the checker; expects clk and rst_n in scope.
`ifndef HUMIDITY_SENSOR_HEATER_AND_AVERAGE_UNIT_MACROS_SVH
`define HUMIDITY_SENSOR_HEATER_AND_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication
`define HSHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HSHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hsha_pkg.sv
// Package for the humidity sensor heater and average unit.
// Widths, reset values, register indexes and shared types. No dependencies.
package hsha_pkg;

  localparam int HUM_W      = 14;
  localparam int TEMP_W     = 15;
  localparam int CNT_W      = 8;
  localparam int BAND_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int RING_DEPTH = 4;
  localparam int RING_POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = HUM_W + $clog2(RING_DEPTH);

  typedef logic [HUM_W-1:0]         hum_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [BAND_W-1:0]        band_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
  typedef logic [RING_POS_W-1:0]    ring_pos_t;
  typedef logic [SUM_W-1:0]         sum_t;

  localparam hum_t  THR_RST      = hum_t'(9600);
  localparam cnt_t  HEAT_ON_RST  = cnt_t'(5);
  localparam cnt_t  COOLDOWN_RST = cnt_t'(15);
  localparam cnt_t  TIMEOUT_RST  = cnt_t'(30);
  localparam band_t BAND_RST     = band_t'(50);
  localparam cnt_t  CNT_MAX      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_THR  = 3'd0,
    REG_HEAT_ON  = 3'd1,
    REG_COOLDOWN = 3'd2,
    REG_TIMEOUT  = 3'd3,
    REG_BAND     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    hum_t  hum_thr;
    cnt_t  heat_on;
    cnt_t  cooldown;
    cnt_t  timeout;
    band_t band;
  } cfg_t;

  // per-sample decision from the heater controller
  typedef struct packed {
    logic ring_wr;   // good read outside a cycle: store sample, publish average
    logic heater;
    logic cycle;
  } ctrl_res_t;

endpackage

FILE: sv/hsha_if.sv
// Channel interfaces for the humidity sensor heater and average unit.
// Depends on hsha_pkg for payload types.
interface hsha_in_if;
  logic                valid;
  logic                ready;
  logic                read_ok;
  hsha_pkg::temp_t     temperature_sample;
  hsha_pkg::hum_t      humidity_sample;

  modport source (output valid, read_ok, temperature_sample, humidity_sample, input ready);
  modport sink   (input valid, read_ok, temperature_sample, humidity_sample, output ready);
endinterface

interface hsha_out_if;
  logic                valid;
  logic                ready;
  logic                update_valid;
  hsha_pkg::hum_t      humidity_average;
  hsha_pkg::temp_t     temperature_out;
  logic                heater_drive;
  logic                cycle_active;
  logic                reinit_request;

  modport source (output valid, update_valid, humidity_average, temperature_out,
                  heater_drive, cycle_active, reinit_request, input ready);
  modport sink   (input valid, update_valid, humidity_average, temperature_out,
                  heater_drive, cycle_active, reinit_request, output ready);
endinterface

interface hsha_cfg_if;
  logic                valid;
  logic                ready;
  hsha_pkg::cfg_idx_t  index;
  hsha_pkg::cfg_data_t wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: sv/hsha_cfg.sv
// Configuration register file: five threshold/count registers.
// Depends on hsha_pkg and hsha_cfg_if.
module hsha_cfg (
  input  logic         clk,
  input  logic         rst_n,
  hsha_cfg_if.sink     cfg_chan,
  output hsha_pkg::cfg_t cfg
);
  import hsha_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_HUM_THR:  cfg_nxt.hum_thr  = cfg_chan.wdata[HUM_W-1:0];
        REG_HEAT_ON:  cfg_nxt.heat_on  = cfg_chan.wdata[CNT_W-1:0];
        REG_COOLDOWN: cfg_nxt.cooldown = cfg_chan.wdata[CNT_W-1:0];
        REG_TIMEOUT:  cfg_nxt.timeout  = cfg_chan.wdata[CNT_W-1:0];
        REG_BAND:     cfg_nxt.band     = cfg_chan.wdata[BAND_W-1:0];
        default:      cfg_nxt = cfg_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hum_thr  <= THR_RST;
      cfg_r.heat_on  <= HEAT_ON_RST;
      cfg_r.cooldown <= COOLDOWN_RST;
      cfg_r.timeout  <= TIMEOUT_RST;
      cfg_r.band     <= BAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/hsha_ctrl.sv
// Heater cycle controller: cooldown, cycle start, on-time and cycle end.
// Depends on hsha_pkg.
module hsha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 commit,
  input  logic                 read_ok,
  input  hsha_pkg::temp_t      temp,
  input  hsha_pkg::hum_t       hum,
  input  hsha_pkg::cfg_t       cfg,
  output hsha_pkg::ctrl_res_t  res
);
  import hsha_pkg::*;

  cnt_t  cnt_r, cnt_nxt;
  cnt_t  cool_r, cool_nxt;
  logic  cyc_r, cyc_nxt;
  logic  heat_r, heat_nxt;
  temp_t entry_r, entry_nxt;

  logic signed [TEMP_W:0] diff;
  logic [TEMP_W:0]        temp_gap;
  cnt_t                   cnt_inc;

  always_comb begin
    diff     = {temp[TEMP_W-1], temp} - {entry_r[TEMP_W-1], entry_r};
    temp_gap = diff[TEMP_W] ? -diff : diff;
    cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + cnt_t'(1);

    cnt_nxt   = cnt_r;
    cool_nxt  = cool_r;
    cyc_nxt   = cyc_r;
    heat_nxt  = heat_r;
    entry_nxt = entry_r;

    if (read_ok) begin
      if (cyc_r) begin
        cnt_nxt = cnt_inc;
        if (heat_r && cnt_inc >= cfg.heat_on)
          heat_nxt = 1'b0;
        // back near entry temperature, or timed out
        if (temp_gap <= (TEMP_W+1)'(cfg.band) || cnt_inc >= cfg.timeout) begin
          cyc_nxt  = 1'b0;
          heat_nxt = 1'b0;
          cool_nxt = cfg.cooldown;
        end
      end else if (cool_r != '0) begin
        cool_nxt = cool_r - cnt_t'(1);
      end else if (hum > cfg.hum_thr) begin
        cyc_nxt   = 1'b1;
        heat_nxt  = 1'b1;
        entry_nxt = temp;
        cnt_nxt   = '0;
      end
    end

    res.ring_wr = read_ok && !cyc_r;
    res.heater  = heat_nxt;
    res.cycle   = cyc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      cool_r  <= '0;
      cyc_r   <= 1'b0;
      heat_r  <= 1'b0;
      entry_r <= '0;
    end else if (commit) begin
      cnt_r   <= cnt_nxt;
      cool_r  <= cool_nxt;
      cyc_r   <= cyc_nxt;
      heat_r  <= heat_nxt;
      entry_r <= entry_nxt;
    end
  end

endmodule

FILE: sv/hsha_ring.sv
// Humidity ring buffer and truncated mean, including the sample being written.
// Depends on hsha_pkg.
module hsha_ring (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  hsha_pkg::hum_t  wr_hum,
  output hsha_pkg::hum_t  avg
);
  import hsha_pkg::*;

  hum_t      ring_r [RING_DEPTH];
  ring_pos_t pos_r, pos_nxt;
  hum_t      view [RING_DEPTH];
  sum_t      sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      view[i] = (wr_en && pos_r == ring_pos_t'(i)) ? wr_hum : ring_r[i];
      sum     = sum + sum_t'(view[i]);
    end
    avg     = hum_t'(sum / RING_DEPTH);
    pos_nxt = (pos_r == ring_pos_t'(RING_DEPTH - 1)) ? '0 : pos_r + ring_pos_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= '0;
    end else if (wr_en) begin
      pos_r <= pos_nxt;
      for (int i = 0; i < RING_DEPTH; i++) ring_r[i] <= view[i];
    end
  end

endmodule

FILE: sv/humidity_sensor_heater_and_average_unit.sv
// Channel     | dir | transaction payload
// in_chan     | in  | read_ok, temperature_sample, humidity_sample
// out_chan    | out | update_valid, humidity_average, temperature_out, heater_drive,
//             |     | cycle_active, reinit_request (one per input transaction)
// cfg_chan    | in  | index, wdata; always ready
//
// One sample per clock unless out_chan stalls. Each sample passes the input register,
// then the heater controller and ring average settle into the output register.
// Synchronous active-low reset restores register defaults and clears the ring.
// A stall on out_chan holds the output register; the input register keeps
// accepting until it is also full.
// Top level; depends on hsha_pkg, hsha_if, hsha_cfg, hsha_ctrl, hsha_ring.
module humidity_sensor_heater_and_average_unit (
  input  logic        clk,
  input  logic        rst_n,
  hsha_in_if.sink     in_chan,
  hsha_out_if.source  out_chan,
  hsha_cfg_if.sink    cfg_chan
);
  import hsha_pkg::*;

  logic      s1_valid_r;
  logic      s1_ok_r;
  temp_t     s1_temp_r;
  hum_t      s1_hum_r;

  logic      out_valid_r;
  logic      out_upd_r;
  hum_t      out_avg_r;
  temp_t     out_temp_r;
  logic      out_heat_r;
  logic      out_cyc_r;
  logic      out_reinit_r;

  logic      advance;
  cfg_t      cfg;
  ctrl_res_t res;
  hum_t      avg;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  hsha_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  hsha_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (advance),
    .read_ok (s1_ok_r),
    .temp    (s1_temp_r),
    .hum     (s1_hum_r),
    .cfg     (cfg),
    .res     (res)
  );

  hsha_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (advance && res.ring_wr),
    .wr_hum (s1_hum_r),
    .avg    (avg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_ok_r   <= in_chan.read_ok;
      s1_temp_r <= in_chan.temperature_sample;
      s1_hum_r  <= in_chan.humidity_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_upd_r    <= res.ring_wr;
      out_avg_r    <= res.ring_wr ? avg : '0;
      out_temp_r   <= res.ring_wr ? s1_temp_r : '0;
      out_heat_r   <= res.heater;
      out_cyc_r    <= res.cycle;
      out_reinit_r <= !s1_ok_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.update_valid     = out_upd_r;
  assign out_chan.humidity_average = out_avg_r;
  assign out_chan.temperature_out  = out_temp_r;
  assign out_chan.heater_drive     = out_heat_r;
  assign out_chan.cycle_active     = out_cyc_r;
  assign out_chan.reinit_request   = out_reinit_r;

endmodule

FILE: sv/hsha_checker.sv
// Port-level checker for the humidity sensor heater and average unit, with its bind.
// Depends on hsha_pkg and the assertion macro header.
`include "humidity_sensor_heater_and_average_unit_macros.svh"

module hsha_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic            update_valid,
  input hsha_pkg::hum_t  humidity_average,
  input hsha_pkg::temp_t temperature_out,
  input logic            heater_drive,
  input logic            cycle_active,
  input logic            reinit_request
);
  import hsha_pkg::*;

  `HSHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(humidity_average) && $stable(temperature_out) && $stable(heater_drive), "output changed while stalled")
  `HSHA_ASSERT_NOW(a_reinit_no_update, out_valid && reinit_request, !update_valid, "failed read produced an update")
  `HSHA_ASSERT_NOW(a_heater_in_cycle, out_valid && heater_drive, cycle_active, "heater driven outside a cycle")
  `HSHA_ASSERT_NOW(a_quiet_fields, out_valid && !update_valid, humidity_average == '0 && temperature_out == '0, "stale data on a non-update transaction")

endmodule

bind humidity_sensor_heater_and_average_unit hsha_checker u_hsha_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .update_valid     (out_chan.update_valid),
  .humidity_average (out_chan.humidity_average),
  .temperature_out  (out_chan.temperature_out),
  .heater_drive     (out_chan.heater_drive),
  .cycle_active     (out_chan.cycle_active),
  .reinit_request   (out_chan.reinit_request)
);

FILE: verif/humidity_sensor_heater_and_average_unit_checker.sv
// Checker for the humidity sensor heater and average unit: watches the sample,
// result and register channels, predicts each result and compares it.
// Depends on hsha_pkg and the channel interfaces in hsha_if.
module humidity_sensor_heater_and_average_unit_checker
  import hsha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hsha_in_if          in_chan,
  hsha_out_if         out_chan,
  hsha_cfg_if         cfg_chan,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic  update_valid;
    hum_t  humidity_average;
    temp_t temperature_out;
    logic  heater_drive;
    logic  cycle_active;
    logic  reinit_request;
  } sensor_update_t;

  // register copy and controller state
  cfg_t      regs;
  hum_t      hum_ring [RING_DEPTH];
  ring_pos_t ring_wr_pos;
  cnt_t      cycle_cnt;
  cnt_t      cooldown_cnt;
  logic      cycle_on;
  logic      heater_state;
  temp_t     entry_temp;

  sensor_update_t predicted_updates[$];
  int unsigned    mismatches = 0;
  int unsigned    waiting = 0;
  int unsigned    results_seen = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic sensor_update_t advance_sensor_state(logic ok, temp_t t, hum_t h);
    sensor_update_t r;
    int diff;
    int sum;
    r = '0;
    r.reinit_request = !ok;
    if (ok) begin
      if (cycle_on) begin
        diff = int'(t) - int'(entry_temp);
        if (diff < 0) diff = -diff;
        if (cycle_cnt != CNT_MAX) cycle_cnt++;
        if (heater_state && cycle_cnt >= regs.heat_on) heater_state = 1'b0;
        if (diff <= int'(regs.band) || cycle_cnt >= regs.timeout) begin
          cycle_on     = 1'b0;
          heater_state = 1'b0;
          cooldown_cnt = regs.cooldown;
        end
      end else begin
        if (cooldown_cnt != '0) begin
          cooldown_cnt--;
        end else if (h > regs.hum_thr) begin
          cycle_on     = 1'b1;
          heater_state = 1'b1;
          entry_temp   = t;
          cycle_cnt    = '0;
        end
        hum_ring[ring_wr_pos] = h;
        ring_wr_pos++;
        sum = 0;
        foreach (hum_ring[i]) sum += int'(hum_ring[i]);
        r.humidity_average = hum_t'(sum / RING_DEPTH);
        r.update_valid     = 1'b1;
        r.temperature_out  = t;
      end
    end
    r.heater_drive = heater_state;
    r.cycle_active = cycle_on;
    return r;
  endfunction

  always @(posedge clk) begin
    sensor_update_t want;
    if (!rst_n) begin
      regs = '{hum_thr: THR_RST, heat_on: HEAT_ON_RST, cooldown: COOLDOWN_RST,
               timeout: TIMEOUT_RST, band: BAND_RST};
      foreach (hum_ring[i]) hum_ring[i] = '0;
      ring_wr_pos  = '0;
      cycle_cnt    = '0;
      cooldown_cnt = '0;
      cycle_on     = 1'b0;
      heater_state = 1'b0;
      entry_temp   = '0;
      predicted_updates.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_reg_e'(cfg_chan.index))
          REG_HUM_THR:  regs.hum_thr  = hum_t'(cfg_chan.wdata);
          REG_HEAT_ON:  regs.heat_on  = cnt_t'(cfg_chan.wdata);
          REG_COOLDOWN: regs.cooldown = cnt_t'(cfg_chan.wdata);
          REG_TIMEOUT:  regs.timeout  = cnt_t'(cfg_chan.wdata);
          REG_BAND:     regs.band     = band_t'(cfg_chan.wdata);
          default: ;  // unused index, write dropped
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        if (predicted_updates.size() == 0) begin
          report_mismatch("result with no transaction outstanding", 1, 0);
        end else begin
          want = predicted_updates.pop_front();
          if (out_chan.update_valid !== want.update_valid)
            report_mismatch("update_valid", out_chan.update_valid, want.update_valid);
          if (out_chan.humidity_average !== want.humidity_average)
            report_mismatch("humidity_average", out_chan.humidity_average,
                            want.humidity_average);
          if (out_chan.temperature_out !== want.temperature_out)
            report_mismatch("temperature_out", int'(out_chan.temperature_out),
                            int'(want.temperature_out));
          if (out_chan.heater_drive !== want.heater_drive)
            report_mismatch("heater_drive", out_chan.heater_drive, want.heater_drive);
          if (out_chan.cycle_active !== want.cycle_active)
            report_mismatch("cycle_active", out_chan.cycle_active, want.cycle_active);
          if (out_chan.reinit_request !== want.reinit_request)
            report_mismatch("reinit_request", out_chan.reinit_request, want.reinit_request);
        end
        results_seen++;
      end
      if (in_chan.valid && in_chan.ready)
        predicted_updates.push_back(advance_sensor_state(in_chan.read_ok,
                                                         in_chan.temperature_sample,
                                                         in_chan.humidity_sample));
    end
    waiting = predicted_updates.size();
  end

endmodule

FILE: verif/humidity_sensor_heater_and_average_unit_tb.sv
// Top of the humidity sensor heater and average unit testbench: clock, reset,
// register settings, sample stimulus with idling and stalls, watchdog and verdict.
// Depends on hsha_pkg, hsha_if, the unit and its checker.
module humidity_sensor_heater_and_average_unit_tb;
  import hsha_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int PHASE_ITEMS     = 90;
  localparam int TEMP_MAX        = 2**(TEMP_W-1) - 1;
  localparam int TEMP_MIN        = -(2**(TEMP_W-1));
  localparam int HUM_MAX         = 2**HUM_W - 1;
  localparam int SPEC_TEMP_LO    = -4500;
  localparam int SPEC_TEMP_HI    = 13000;
  localparam int SPEC_HUM_HI     = 10000;

  logic        clk;
  logic        rst_n;
  logic        sink_ready = 1'b0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned fail_count;
  int unsigned pending;
  int          stuck_cycles = 0;
  int          items_sent = 0;
  cfg_t        regs_now;

  hsha_in_if  in_chan ();
  hsha_out_if out_chan ();
  hsha_cfg_if cfg_chan ();

  assign out_chan.ready = sink_ready;

  humidity_sensor_heater_and_average_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  humidity_sensor_heater_and_average_unit_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_chan   (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    sink_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // watchdog: cycles without any transaction on any channel
  always @(posedge clk) begin
    if (rst_n && !((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
                   (cfg_chan.valid && cfg_chan.ready)))
      stuck_cycles++;
    else
      stuck_cycles = 0;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic temp_t clamp_temp(int v);
    if (v > TEMP_MAX) v = TEMP_MAX;
    if (v < TEMP_MIN) v = TEMP_MIN;
    return temp_t'(v);
  endfunction

  function automatic temp_t spec_temp();
    return clamp_temp(int'($urandom_range(0, SPEC_TEMP_HI - SPEC_TEMP_LO)) + SPEC_TEMP_LO);
  endfunction

  function automatic hum_t hum_below();
    return hum_t'($urandom_range(0, int'(regs_now.hum_thr)));
  endfunction

  task automatic send_sample(logic ok, temp_t t, hum_t h);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid              = 1'b1;
    in_chan.read_ok            = ok;
    in_chan.temperature_sample = t;
    in_chan.humidity_sample    = h;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.wdata = val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic settle();
    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(cfg_data_t thr, cfg_data_t on_time, cfg_data_t cool,
                                cfg_data_t tmo, cfg_data_t band);
    settle();
    write_reg(REG_HUM_THR, thr);
    write_reg(REG_HEAT_ON, on_time);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_BAND, band);
    regs_now = '{hum_thr: hum_t'(thr), heat_on: cnt_t'(on_time), cooldown: cnt_t'(cool),
                 timeout: cnt_t'(tmo), band: band_t'(band)};
  endtask

  // a few ring samples, a start, samples away from entry, a return, then cooldown
  task automatic run_episode();
    int   base;
    int   offset;
    int   lim;
    hum_t h;
    repeat ($urandom_range(0, 3)) send_sample(1'b1, spec_temp(), hum_below());
    base = int'(spec_temp());
    if (regs_now.hum_thr >= SPEC_HUM_HI)
      h = hum_t'($urandom_range(int'(regs_now.hum_thr), HUM_MAX));
    else
      h = hum_t'($urandom_range(int'(regs_now.hum_thr) + 1, SPEC_HUM_HI));
    send_sample(1'b1, temp_t'(base), h);
    lim = int'(regs_now.timeout) + 2;
    if (lim > 40) lim = 40;
    repeat ($urandom_range(0, lim)) begin
      if ($urandom_range(99) < 10) begin
        send_sample(1'b0, temp_t'($urandom), hum_t'($urandom));
      end else begin
        offset = int'(regs_now.band) + 1 + int'($urandom_range(0, 2000));
        if ($urandom_range(1) != 0) offset = -offset;
        send_sample(1'b1, clamp_temp(base + offset), hum_t'($urandom));
      end
    end
    send_sample(1'b1, clamp_temp(base + int'($urandom_range(0, 2 * int'(regs_now.band)))
                                 - int'(regs_now.band)), hum_t'($urandom));
    lim = int'(regs_now.cooldown) + 1;
    if (lim > 20) lim = 20;
    repeat ($urandom_range(0, lim)) send_sample(1'b1, spec_temp(), hum_below());
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 5))
      send_sample($urandom_range(99) < 80, temp_t'($urandom), hum_t'($urandom));
  endtask

  task automatic run_random(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) run_episode();
      else run_noise();
      if ($urandom_range(99) < 3) settle();
    end
  endtask

  initial begin
    rst_n                      = 1'b0;
    in_chan.valid              = 1'b0;
    in_chan.read_ok            = 1'b0;
    in_chan.temperature_sample = '0;
    in_chan.humidity_sample    = '0;
    cfg_chan.valid             = 1'b0;
    cfg_chan.index             = '0;
    cfg_chan.wdata             = '0;
    regs_now = '{hum_thr: THR_RST, heat_on: HEAT_ON_RST, cooldown: COOLDOWN_RST,
                 timeout: TIMEOUT_RST, band: BAND_RST};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, default registers
    send_sample(1'b1, temp_t'(SPEC_TEMP_LO), '0);
    send_sample(1'b0, temp_t'(TEMP_MAX), hum_t'(HUM_MAX));   // failed read, humidity all ones
    send_sample(1'b0, temp_t'(TEMP_MIN), '0);
    send_sample(1'b1, temp_t'(SPEC_TEMP_HI), hum_t'(SPEC_HUM_HI));  // starts a cycle
    send_sample(1'b1, temp_t'(TEMP_MIN), hum_t'(HUM_MAX));
    send_sample(1'b0, '0, '0);                               // failed read in cycle
    repeat (4) send_sample(1'b1, temp_t'(SPEC_TEMP_HI - 1000), '0);  // on-time runs out
    send_sample(1'b1, temp_t'(SPEC_TEMP_HI + int'(BAND_RST)), '0);  // band edge ends it
    repeat (4) send_sample(1'b1, temp_t'(TEMP_MAX), hum_t'(HUM_MAX)); // cooldown, full ring
    send_sample(1'b1, temp_t'(SPEC_TEMP_LO), hum_t'(SPEC_HUM_HI));
    settle();
    // unused indexes must not disturb the registers
    for (int k = 1; k <= 3; k++)
      write_reg(cfg_idx_t'(REG_BAND) + cfg_idx_t'(k), cfg_data_t'($urandom));
    send_sample(1'b1, temp_t'(SPEC_TEMP_LO), hum_t'(HUM_MAX));
    repeat (3) send_sample(1'b1, temp_t'(SPEC_TEMP_LO + 2000), '0);

    // zero registers: cycle ends on its first sample, no cooldown
    apply_settings('0, '0, '0, '0, '0);
    in_idle_pct   = 86;
    out_stall_pct = 0;
    run_random(PHASE_ITEMS);

    apply_settings(cfg_data_t'(SPEC_HUM_HI), cfg_data_t'(CNT_MAX), cfg_data_t'(CNT_MAX),
                   cfg_data_t'(CNT_MAX), cfg_data_t'(2**BAND_W - 1));
    in_idle_pct   = 0;
    out_stall_pct = 86;
    run_random(PHASE_ITEMS);

    apply_settings(cfg_data_t'($urandom_range(0, SPEC_HUM_HI)), cfg_data_t'($urandom_range(1, 16)),
                   cfg_data_t'($urandom_range(0, 8)), cfg_data_t'($urandom_range(1, 40)),
                   cfg_data_t'($urandom_range(0, 1000)));
    in_idle_pct   = 37;
    out_stall_pct = 37;
    run_random(PHASE_ITEMS);

    // full-width writes: upper bits of the narrower registers are dropped
    apply_settings(cfg_data_t'($urandom), cfg_data_t'($urandom), cfg_data_t'($urandom),
                   cfg_data_t'($urandom), cfg_data_t'($urandom));
    in_idle_pct   = 0;
    out_stall_pct = 0;
    run_random(PHASE_ITEMS);

    apply_settings(cfg_data_t'($urandom_range(0, SPEC_HUM_HI)), cfg_data_t'($urandom_range(1, 8)),
                   cfg_data_t'($urandom_range(0, 4)), cfg_data_t'($urandom_range(1, 20)),
                   cfg_data_t'($urandom_range(0, 300)));
    run_random(PHASE_ITEMS);

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/hsha_pkg.sv
sv/hsha_if.sv
sv/hsha_cfg.sv
sv/hsha_ctrl.sv
sv/hsha_ring.sv
sv/humidity_sensor_heater_and_average_unit.sv
sv/hsha_checker.sv
verif/humidity_sensor_heater_and_average_unit_checker.sv
verif/humidity_sensor_heater_and_average_unit_tb.sv
